// File: rtl/jpd_pkg.sv
`default_nettype none
package jpd_pkg;

  localparam int unsigned MaxStages = 24;
  localparam int unsigned FullScale = 32767;

  // Arc tangent of 2^-i, in 2^-32 turns.
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/joystick_polar_deadzone_top.sv
`default_nettype none
// Channel   Ports                                          Direction
// input     in_valid/in_ready, stick_select, four axes     request in
// result    out_valid/out_ready, out_strength, out_heading  request out
// config    cfg_we, cfg_data (dead zone radius)            write only
//
// One request can enter every cycle. Its result is offered after the request
// passes one select stage, then the longer of two parallel paths, then one
// output register. The magnitude path is 18 stages: square, eight square root
// stages at two bits each, a setup stage and eight divider stages at two
// quotient bits each. The rotation path is ROTATION_STAGES + 1 stages, so above
// 17 rotation stages it is the longer path. Reset is synchronous. It clears the
// valid bits of every stage and sets the dead zone to 7849. When a result waits
// at the output the whole pipeline holds, bubbles included. The input is
// blocked only while that result waits.
module joystick_polar_deadzone_top #(
  parameter int ROTATION_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_stick_select,
  input  wire logic [15:0] in_left_x,
  input  wire logic [15:0] in_left_y,
  input  wire logic [15:0] in_right_x,
  input  wire logic [15:0] in_right_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_strength,
  output logic [16:0]      out_heading,
  input  wire logic        cfg_we,
  input  wire logic [14:0] cfg_data
);

  // Square root: 16 result bits, two per stage -> 8 stages.
  // Divider: 16 quotient bits, two per stage -> 8 stages.
  localparam int SqStages  = 8;
  localparam int DivStages = 8;
  // Front stage (square/select), then square root, then divider; the
  // rotation runs in parallel, and the shorter path is padded to the same total depth.
  localparam int MagDepth  = 1 + SqStages + 1 + DivStages;
  localparam int AngDepth  = 1 + ROTATION_STAGES;
  localparam int Depth     = (MagDepth > AngDepth) ? MagDepth : AngDepth;
  // One more register aligns both paths after Depth, so the output valid
  // bit sits at index Depth + 1.
  localparam int Stages    = Depth + 2;

  logic [14:0] dz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= 15'd7849;
    end else if (cfg_we) begin
      dz_r <= cfg_data;
    end
  end

  // Global stall: the pipeline advances when the output is empty or taken.
  logic adv;
  logic [Stages-1:0] v_r;
  assign adv      = !v_r[Stages-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[Stages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // ---------------- Stage 0: select and square ----------------
  logic signed [15:0] x_r, y_r;
  logic [14:0]        dz0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= in_stick_select ? in_right_x : in_left_x;
      y_r   <= in_stick_select ? in_right_y : in_left_y;
      dz0_r <= dz_r;
    end
  end

  logic [31:0] xx_nxt, yy_nxt;
  assign xx_nxt = 32'($signed(x_r) * $signed(x_r));
  assign yy_nxt = 32'($signed(y_r) * $signed(y_r));

  // ---------------- Magnitude path ----------------
  // Stage 1 registers the sum and the dead-zone compare flags as the first
  // entry of the square root pipeline.
  logic [31:0] sum_nxt;
  logic [29:0] dzsq_nxt;
  assign sum_nxt  = xx_nxt + yy_nxt;
  assign dzsq_nxt = 30'(dz0_r) * 30'(dz0_r);

  // Square root pipeline, two result bits per stage.
  logic [31:0] sq_rem_r [SqStages+1];
  logic [15:0] sq_root_r [SqStages+1];
  logic [14:0] sq_dz_r  [SqStages+1];
  logic        sq_gt_r  [SqStages+1];
  logic        sq_ge_r  [SqStages+1];
  logic        sq_cz_r  [SqStages+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= sum_nxt;
      sq_root_r[0] <= '0;
      sq_dz_r[0]   <= dz0_r;
      sq_gt_r[0]   <= sum_nxt > {2'b00, dzsq_nxt};
      sq_ge_r[0]   <= sum_nxt >= {2'b00, dzsq_nxt};
      sq_cz_r[0]   <= (dz0_r == 15'(jpd_pkg::FullScale));
    end
  end

  for (genvar s = 0; s < SqStages; s++) begin : g_sq
    logic [31:0] rem, trial;
    logic [15:0] root;
    always_comb begin
      rem  = sq_rem_r[s];
      root = sq_root_r[s];
      for (int b = 0; b < 2; b++) begin
        // root holds bits found so far; compare against (4r+1)*4^k.
        trial = ({14'd0, root, 2'b01}) << (30 - 4 * s - 2 * b);
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[14:0], 1'b1};
        end else begin
          root = {root[14:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[s+1]  <= rem;
        sq_root_r[s+1] <= root;
        sq_dz_r[s+1]   <= sq_dz_r[s];
        sq_gt_r[s+1]   <= sq_gt_r[s];
        sq_ge_r[s+1]   <= sq_ge_r[s];
        sq_cz_r[s+1]   <= sq_cz_r[s];
      end
    end
  end

  // Clip, then set up the division (m - dz) * 32768 / (32767 - dz).
  logic [15:0] m_clip;
  assign m_clip = (sq_root_r[SqStages] > 16'(jpd_pkg::FullScale)) ?
                  16'(jpd_pkg::FullScale) : sq_root_r[SqStages];

  logic [31:0] dv_rem_r [DivStages+1];
  logic [14:0] dv_den_r [DivStages+1];
  logic [15:0] dv_q_r   [DivStages+1];
  logic        dv_ok_r  [DivStages+1];
  logic        dv_ge_r  [DivStages+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= {1'b0, 15'(m_clip - 16'(sq_dz_r[SqStages])), 16'd0} >> 1;
      dv_den_r[0] <= 15'(16'(jpd_pkg::FullScale) - 16'(sq_dz_r[SqStages]));
      dv_q_r[0]   <= '0;
      dv_ok_r[0]  <= sq_gt_r[SqStages] && !sq_cz_r[SqStages] &&
                     (m_clip > 16'(sq_dz_r[SqStages]));
      dv_ge_r[0]  <= sq_ge_r[SqStages];
    end
  end

  // Restoring division: numerator n = d15*2^15 (d15 < 2^15), quotient <= 32768.
  // Remainder held as n; at quotient bit k compare with den << k.
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    logic [31:0] rem;
    logic [15:0] q;
    logic [31:0] sh;
    always_comb begin
      rem = dv_rem_r[s];
      q   = dv_q_r[s];
      for (int b = 0; b < 2; b++) begin
        sh = {17'd0, dv_den_r[s]} << (15 - 2 * s - b);
        if (rem >= sh) begin
          rem = rem - sh;
          q   = {q[14:0], 1'b1};
        end else begin
          q   = {q[14:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[s+1] <= rem;
        dv_q_r[s+1]   <= q;
        dv_den_r[s+1] <= dv_den_r[s];
        dv_ok_r[s+1]  <= dv_ok_r[s];
        dv_ge_r[s+1]  <= dv_ge_r[s];
      end
    end
  end

  logic [15:0] strength_mag;
  logic        ge_mag;
  assign strength_mag = dv_ok_r[DivStages] ? dv_q_r[DivStages] : 16'd0;
  assign ge_mag       = dv_ge_r[DivStages];

  // ---------------- Heading path ----------------
  logic [16:0] head_ang;
  jpd_cordic #(.ROTATION_STAGES(ROTATION_STAGES)) u_cordic (
    .clk     (clk),
    .adv     (adv),
    .x       (x_r),
    .y       (y_r),
    .heading (head_ang)
  );

  // Align both paths to the same depth with short delay lines.
  localparam int MagPad = Depth - MagDepth + 1;
  localparam int AngPad = Depth - AngDepth + 1;
  logic [16:0] mpad_r [MagPad];
  logic [16:0] apad_r [AngPad];
  always_ff @(posedge clk) begin
    if (adv) begin
      mpad_r[0] <= {strength_mag, ge_mag};
      apad_r[0] <= head_ang;
      for (int i = 1; i < MagPad; i++) mpad_r[i] <= mpad_r[i-1];
      for (int i = 1; i < AngPad; i++) apad_r[i] <= apad_r[i-1];
    end
  end

  assign out_strength = mpad_r[MagPad-1][16:1];
  assign out_heading  = mpad_r[MagPad-1][0] ? apad_r[AngPad-1] : 17'd0;

endmodule
`default_nettype wire

// File: rtl/jpd_cordic.sv
`default_nettype none
// Vectoring rotation, one micro-rotation per register stage.
// x and y pass an input register, then the rotation stages.
module jpd_cordic #(
  parameter int ROTATION_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  output logic [16:0]             heading
);

  localparam int W = 36;

  typedef struct packed {
    logic               fixed;
    logic [16:0]        fixed_val;
  } axis_t;

  logic signed [W-1:0] px_r [ROTATION_STAGES+1];
  logic signed [W-1:0] py_r [ROTATION_STAGES+1];
  logic [31:0]         acc_r [ROTATION_STAGES+1];
  axis_t               ax_r  [ROTATION_STAGES+1];

  logic signed [W-1:0] px0, py0;
  axis_t               ax0;
  always_comb begin
    px0 = W'(y) <<< 16;
    py0 = -(W'(x) <<< 16);
    ax0.fixed     = (x == 16'sd0) || (y == 16'sd0);
    if (x == 16'sd0) begin
      ax0.fixed_val = y[15] ? 17'd32768 : 17'd65536;
    end else begin
      ax0.fixed_val = x[15] ? 17'd16384 : 17'd49152;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r[0]  <= y[15] ? -px0 : px0;
      py_r[0]  <= y[15] ? -py0 : py0;
      acc_r[0] <= y[15] ? 32'h8000_0000 : 32'd0;
      ax_r[0]  <= ax0;
    end
  end

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    logic signed [W-1:0] dx, dy;
    assign dx = py_r[i] >>> i;
    assign dy = px_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!py_r[i][W-1]) begin
          px_r[i+1]  <= px_r[i] + dx;
          py_r[i+1]  <= py_r[i] - dy;
          acc_r[i+1] <= acc_r[i] + jpd_pkg::atan_turns(5'(i));
        end else begin
          px_r[i+1]  <= px_r[i] - dx;
          py_r[i+1]  <= py_r[i] + dy;
          acc_r[i+1] <= acc_r[i] - jpd_pkg::atan_turns(5'(i));
        end
        ax_r[i+1] <= ax_r[i];
      end
    end
  end

  logic [32:0] rnd;
  logic [16:0] h;
  assign rnd = {1'b0, acc_r[ROTATION_STAGES]} + 33'd32768;
  assign h   = rnd[32:16];
  assign heading = ax_r[ROTATION_STAGES].fixed ? ax_r[ROTATION_STAGES].fixed_val :
                   ((h == 17'd0) ? 17'd65536 : h);

endmodule
`default_nettype wire

// File: rtl/jpd_checker.sv
`default_nettype none
module jpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_strength,
  input wire logic [16:0] out_heading
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_strength) && $stable(out_heading))
    else $error("result changed under stall");

  a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_strength <= 16'd32768)
    else $error("strength out of range");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading <= 17'd65536)
    else $error("heading out of range");

  a_strength_implies_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_strength != 16'd0 |-> out_heading != 17'd0)
    else $error("strength outside dead zone without heading");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind joystick_polar_deadzone_top jpd_checker u_jpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_strength (out_strength),
  .out_heading  (out_heading)
);
`default_nettype wire

// File: test/tb_joystick_polar_deadzone_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_joystick_polar_deadzone_top;

  localparam int RotStages = 16;
  localparam int Latency = 40;
  localparam int CycleLimit = 600000;
  localparam logic [14:0] DeadZoneReset = 15'd7849;

  // One pending request for the input channel.
  typedef struct packed {
    logic        sel;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } stick_req_t;

  // One predicted polar result.
  typedef struct packed {
    logic [15:0] strength;
    logic [16:0] heading;
  } polar_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_stick_select;
  logic [15:0] in_left_x;
  logic [15:0] in_left_y;
  logic [15:0] in_right_x;
  logic [15:0] in_right_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_strength;
  logic [16:0] out_heading;
  logic        cfg_we;
  logic [14:0] cfg_data;

  stick_req_t pending_reqs[$];
  polar_res_t expected_polar[$];
  logic [14:0] model_dead_zone;
  int          mismatch_count;
  int          cycle_count;
  int          send_gap;
  int          recv_gap;
  bit          hold_off_req;
  int          hold_off_left;
  bit          random_gaps;

  joystick_polar_deadzone_top #(
    .ROTATION_STAGES(RotStages)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stick_select(in_stick_select),
    .in_left_x      (in_left_x),
    .in_left_y      (in_left_y),
    .in_right_x     (in_right_x),
    .in_right_y     (in_right_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_strength   (out_strength),
    .out_heading    (out_heading),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Integer square root, rounded down.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Vectoring rotation toward the positive axis; the angle sum is in 2^-32 turns.
  function automatic logic [16:0] stick_heading(input longint x, input longint y);
    longint px, py, dx, dy;
    logic [31:0] angle;
    logic [32:0] rounded;
    angle = '0;
    if (x == 0) return (y < 0) ? 17'd32768 : 17'd65536;
    if (y == 0) return (x > 0) ? 17'd49152 : 17'd16384;
    px = y * 65536;
    py = -x * 65536;
    if (px < 0) begin
      px = -px;
      py = -py;
      angle = 32'h8000_0000;
    end
    for (int i = 0; i < RotStages && i < jpd_pkg::MaxStages; i++) begin
      // An arithmetic shift of a signed value is already a floor shift.
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx;
        py -= dy;
        angle += jpd_pkg::atan_turns(5'(i));
      end else begin
        px -= dx;
        py += dy;
        angle -= jpd_pkg::atan_turns(5'(i));
      end
    end
    rounded = ({1'b0, angle} + 33'd32768) >> 16;
    if (rounded[16:0] == 17'd0) return 17'd65536;
    return rounded[16:0];
  endfunction

  function automatic polar_res_t predict_polar(input stick_req_t r, input logic [14:0] dz);
    polar_res_t res;
    longint x, y;
    longint unsigned sum, dzsq, mag;
    x = r.sel ? longint'($signed(r.rx)) : longint'($signed(r.lx));
    y = r.sel ? longint'($signed(r.ry)) : longint'($signed(r.ly));
    sum = x * x + y * y;
    dzsq = longint'(dz) * longint'(dz);
    res = '0;
    if (sum > dzsq && dz < jpd_pkg::FullScale) begin
      mag = floor_sqrt(sum);
      if (mag > jpd_pkg::FullScale) mag = jpd_pkg::FullScale;
      if (mag > dz)
        res.strength = 16'(((mag - dz) * 32768) / (jpd_pkg::FullScale - dz));
    end
    if (sum >= dzsq) res.heading = stick_heading(x, y);
    return res;
  endfunction

  // Driver: offer the head of the queue after a drawn gap, hold it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // The request stays on the port unchanged until it is taken.
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      stick_req_t r;
      r = pending_reqs.pop_front();
      in_valid        <= 1'b1;
      in_stick_select <= r.sel;
      in_left_x       <= r.lx;
      in_left_y       <= r.ly;
      in_right_x      <= r.rx;
      in_right_y      <= r.ry;
      expected_polar.push_back(predict_polar(r, model_dead_zone));
      send_gap <= random_gaps ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: randomly stall, with an occasional long hold-off requested by the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      hold_off_left <= 0;
    end else if (hold_off_req && hold_off_left == 0 && out_ready) begin
      out_ready <= 1'b0;
      hold_off_left <= 200;
    end else if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (out_valid && out_ready && random_gaps && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      recv_gap <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_polar.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result strength=%0d heading=%0d",
                   out_strength, out_heading);
      end else begin
        polar_res_t e;
        e = expected_polar.pop_front();
        if (e.strength !== out_strength || e.heading !== out_heading) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: strength exp %0d got %0d, heading exp %0d got %0d",
                     e.strength, out_strength, e.heading, out_heading);
        end
      end
    end
  end

  // The run ends on a hard cycle limit if the pipeline ever hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_req(input logic sel, input logic [15:0] x, input logic [15:0] y);
    stick_req_t r;
    r.sel = sel;
    r.lx = $urandom();
    r.ly = $urandom();
    r.rx = $urandom();
    r.ry = $urandom();
    if (sel) begin
      r.rx = x;
      r.ry = y;
    end else begin
      r.lx = x;
      r.ly = y;
    end
    pending_reqs.push_back(r);
  endtask

  // Waits until every request has gone in and every result has come out.
  task automatic drain;
    while (pending_reqs.size() > 0 || expected_polar.size() > 0 || in_valid)
      @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_dead_zone(input logic [14:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    model_dead_zone = value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // A random point: raw, near the dead zone edge, near the center, or of a random scale and sign.
  task automatic add_random_req(input logic [14:0] dz);
    logic [15:0] x, y;
    int radius, k;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      x = $urandom();
      y = $urandom();
    end else if (k < 5) begin
      // Around the dead zone edge, on an axis, on a diagonal or on a 3-4-5 direction.
      radius = int'(dz) + $urandom_range(0, 4) - 2;
      if (radius < 0) radius = 0;
      case ($urandom_range(0, 3))
        0: begin x = 16'(radius); y = 0; end
        1: begin x = 0; y = -16'(radius); end
        2: begin x = 16'(radius * 7 / 10); y = 16'(radius * 7 / 10); end
        default: begin x = -16'(radius * 3 / 5); y = 16'(radius * 4 / 5); end
      endcase
    end else if (k < 6) begin
      // Small deflections near the center.
      x = 16'($urandom_range(0, 64) - 32);
      y = 16'($urandom_range(0, 64) - 32);
    end else begin
      x = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
      y = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
      if ($urandom_range(0, 1)) x = -x;
      if ($urandom_range(0, 1)) y = -y;
    end
    add_req(1'($urandom_range(0, 1)), x, y);
  endtask

  initial begin
    logic [14:0] dz_settings[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stick_select = 1'b0;
    in_left_x = '0;
    in_left_y = '0;
    in_right_x = '0;
    in_right_y = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cycle_count = 0;
    mismatch_count = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_off_req = 1'b0;
    hold_off_left = 0;
    random_gaps = 1'b0;
    model_dead_zone = DeadZoneReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset dead zone: axes, corners, the edge and the center.
    add_req(1'b0, 16'h0000, 16'h7FFF);
    add_req(1'b1, 16'h0000, 16'h8000);
    add_req(1'b0, 16'h7FFF, 16'h0000);
    add_req(1'b1, 16'h8000, 16'h0000);
    add_req(1'b0, 16'h8000, 16'h8000);
    add_req(1'b1, 16'h7FFF, 16'h7FFF);
    add_req(1'b0, 16'h7FFF, 16'h8000);
    add_req(1'b1, 16'h8000, 16'h7FFF);
    add_req(1'b0, 16'(7849), 16'h0000);
    add_req(1'b1, 16'h0000, -16'(7849));
    add_req(1'b0, 16'(7848), 16'h0000);
    add_req(1'b1, 16'h0000, 16'(7850));
    add_req(1'b0, 16'h0000, 16'h0000);
    add_req(1'b1, 16'h0001, 16'hFFFF);
    add_req(1'b0, 16'hFFFF, 16'h4000);
    add_req(1'b1, 16'h4000, 16'hC001);
    drain();

    // A zero dead zone: the zero vector points straight up at zero strength.
    write_dead_zone(15'd0);
    add_req(1'b0, 16'h0000, 16'h0000);
    add_req(1'b1, 16'h0000, 16'h0000);
    add_req(1'b0, 16'h0001, 16'h0000);
    add_req(1'b1, 16'h8000, 16'h8000);
    drain();

    // The dead zone at its top: the divisor vanishes, so strength stays zero.
    write_dead_zone(15'h7FFF);
    add_req(1'b0, 16'h7FFF, 16'h7FFF);
    add_req(1'b1, 16'h0000, 16'h7FFF);
    add_req(1'b0, 16'h8000, 16'h0000);
    drain();

    // Random phases across several dead zone settings, with random gaps on both sides.
    random_gaps = 1'b1;
    dz_settings[0] = 15'd0;
    dz_settings[1] = 15'd32766;
    dz_settings[2] = DeadZoneReset;
    dz_settings[3] = 15'($urandom_range(1, 32765));
    dz_settings[4] = 15'($urandom_range(0, 400));
    foreach (dz_settings[p]) begin
      write_dead_zone(dz_settings[p]);
      for (int i = 0; i < 200; i++) add_random_req(dz_settings[p]);
      if (p == 2) begin
        // Stall the receiver for a long stretch while requests keep coming.
        @(posedge clk);
        hold_off_req = 1'b1;
        while (hold_off_left == 0) @(posedge clk);
        hold_off_req = 1'b0;
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
